FILE: rtl/core/rtpq_pkg.sv
// Shared types and constants for the resistive touch point qualifier.
// Holds the input and result word layouts and the register map.
// No dependencies.
package rtpq_pkg;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned RegDataW = 13;
  localparam int unsigned RunW     = 8;

  localparam logic [CoordW-1:0] FullScale = 12'd4095;
  localparam logic [RunW-1:0]   RunMax    = 8'd255;

  localparam logic [RegDataW-1:0] MaxSize = 13'd4096;

  localparam logic [RegDataW-1:0] ThresholdRst = 13'd400;
  localparam logic [RunW-1:0]     DebounceRst  = 8'd2;
  localparam logic [RegDataW-1:0] WidthRst     = 13'd240;
  localparam logic [RegDataW-1:0] HeightRst    = 13'd320;

  typedef enum logic [RegIdxW-1:0] {
    REG_ENABLE    = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_DEBOUNCE  = 3'd2,
    REG_WIDTH     = 3'd3,
    REG_HEIGHT    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] pressure_one;
    logic [CoordW-1:0] pressure_two;
    logic [CoordW-1:0] raw_x;
    logic [CoordW-1:0] raw_y;
  } in_word_t;

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              pressed;
  } out_word_t;

endpackage

FILE: rtl/core/rtpq_if.sv
// Valid/ready channel carrying one word of a given type.
// Depends on the word type supplied at instantiation.
interface rtpq_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

FILE: rtl/core/resistive_touch_point_qualifier.sv
// Resistive touch point qualifier: pressure gate, debounce and screen scaling.
// Depends on rtpq_pkg and rtpq_if.
// Takes one word per clock when the output side keeps up; an accepted word is
// held in the input register and its result word then in the output register.
// The rate is set by the scaling stage: one 12x12 multiply per axis, a divide by
// 4095 via a shift, add and compare, and the press counter update, all combinational.
// A result waiting in the output register does not block the input register from
// filling; the input stalls only when both registers hold a word.
module resistive_touch_point_qualifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rtpq_pkg::RegIdxW-1:0]      cfg_index_i,
  input  logic [rtpq_pkg::RegDataW-1:0]     cfg_data_i,
  rtpq_if.sink                              in_if,
  rtpq_if.source                            out_if
);
  import rtpq_pkg::*;

  function automatic logic [CoordW-1:0] map_axis(
    input logic [CoordW-1:0]   raw,
    input logic [RegDataW-1:0] size
  );
    logic [CoordW-1:0]   span;
    logic [2*CoordW-1:0] prod;
    logic [CoordW:0]     fold;
    logic [CoordW-1:0]   quot;
    if (size == '0) begin
      span = '0;
    end else if (size > MaxSize) begin
      span = FullScale;
    end else begin
      span = CoordW'(size - RegDataW'(1));
    end
    prod = (2*CoordW)'(raw) * (2*CoordW)'(span);
    fold = {1'b0, prod[2*CoordW-1:CoordW]} + {1'b0, prod[CoordW-1:0]};
    quot = prod[2*CoordW-1:CoordW] + CoordW'(fold >= {1'b0, FullScale});
    return span - quot;
  endfunction

  logic                enable_q;
  logic [RegDataW-1:0] threshold_q;
  logic [RunW-1:0]     debounce_q;
  logic [RegDataW-1:0] width_q;
  logic [RegDataW-1:0] height_q;

  logic              s1_valid_q;
  in_word_t          s1_word_q;
  logic              s1_adv;
  logic              out_valid_q;
  out_word_t         out_q, out_d;

  logic [RunW-1:0]   run_q, run_d;
  logic [CoordW-1:0] held_x_q, held_x_d;
  logic [CoordW-1:0] held_y_q, held_y_d;
  logic [RegDataW-1:0] pressure;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      threshold_q <= ThresholdRst;
      debounce_q  <= DebounceRst;
      width_q     <= WidthRst;
      height_q    <= HeightRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ENABLE:    enable_q    <= cfg_data_i[0];
        REG_THRESHOLD: threshold_q <= cfg_data_i;
        REG_DEBOUNCE:  debounce_q  <= cfg_data_i[RunW-1:0];
        REG_WIDTH:     width_q     <= cfg_data_i;
        REG_HEIGHT:    height_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s1_adv       = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !s1_valid_q || s1_adv;
  assign out_if.valid = out_valid_q;
  assign out_if.word  = out_q;

  always_comb begin
    pressure = RegDataW'(s1_word_q.pressure_one) + RegDataW'(FullScale)
             - RegDataW'(s1_word_q.pressure_two);
    run_d    = run_q;
    held_x_d = held_x_q;
    held_y_d = held_y_q;
    out_d.pressed = 1'b0;
    if (enable_q) begin
      if (pressure < threshold_q) begin
        run_d = '0;
      end else begin
        held_x_d = map_axis(s1_word_q.raw_x, width_q);
        held_y_d = map_axis(s1_word_q.raw_y, height_q);
        run_d    = (run_q < RunMax) ? run_q + RunW'(1) : run_q;
        out_d.pressed = (run_d >= debounce_q);
      end
    end
    out_d.point_x = held_x_d;
    out_d.point_y = held_y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      run_q       <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
    end else begin
      if (in_if.ready) begin
        s1_valid_q <= in_if.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        run_q       <= run_d;
        held_x_q    <= held_x_d;
        held_y_q    <= held_y_d;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_word_q <= in_if.word;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_word_q)))
    else $error("input stage lost a stalled word");

  a_out_tracks_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.point_x == held_x_q && out_q.point_y == held_y_q))
    else $error("result point differs from held point");

  a_run_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q != $past(run_q)) |-> (run_q == '0 || run_q == $past(run_q) + RunW'(1)))
    else $error("press counter moved by more than one");

  a_pressed_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.pressed) |-> (run_q != '0))
    else $error("pressed result with empty press counter");

endmodule
